>>> src/irb_pkg.sv
// -----------------------------------------------------------------------------
// irb_pkg: shared types and constants of the bilinear image resizer
// Payload structs of the pixel and configuration channels, register indexes,
// operation codes and register reset values.
// -----------------------------------------------------------------------------
package irb_pkg;

	typedef struct packed {
		logic        action;
		logic [11:0] pos_row;
		logic [11:0] pos_col;
		logic [7:0]  in_chan0;
		logic [7:0]  in_chan1;
		logic [7:0]  in_chan2;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_chan0;
		logic [7:0] out_chan1;
		logic [7:0] out_chan2;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [19:0] value;
	} cfg_item_t;

	localparam logic [2:0] CFG_SCALE_X       = 3'd0;
	localparam logic [2:0] CFG_SCALE_Y       = 3'd1;
	localparam logic [2:0] CFG_SOURCE_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_SOURCE_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_INTERP_MODE   = 3'd4;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic MODE_NEAREST = 1'b0;
	localparam logic MODE_LINEAR  = 1'b1;

	localparam logic [19:0] SCALE_RESET = 20'd65536;
	localparam logic [9:0]  SIZE_RESET  = 10'd512;

endpackage

>>> src/irb_stream_if.sv
// -----------------------------------------------------------------------------
// irb_stream_if: valid/ready channel
// Carries one payload of type T per beat; a beat moves when valid and ready
// are both high at a rising clock edge.
// -----------------------------------------------------------------------------
interface irb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/irb_axis.sv
// -----------------------------------------------------------------------------
// irb_axis: coordinate mapping for one axis
// Multiplies the destination coordinate by the scale, then splits the source
// position into a clamped integer index and the leading interpolation weight.
// -----------------------------------------------------------------------------
module irb_axis #(
	parameter int PW = 9,
	parameter int W  = 11
) (
	input  logic          clk,
	input  logic          en,
	input  logic [11:0]   coord,
	input  logic [19:0]   scale,
	input  logic          linear,
	input  logic [PW-1:0] last_idx,
	output logic [PW-1:0] pos_s2,
	output logic [W:0]    w0_s2
);

	localparam logic [W:0] ONE = (W+1)'(1) << W;
	localparam logic MODE_LINEAR_BIT = irb_pkg::MODE_LINEAR;

	logic [12:0] mult_op;
	logic [32:0] prod_s1;
	logic        linear_s1;
	logic [34:0] t;
	logic [16:0] t_int;
	logic [16:0] t_frac;
	logic [16:0] near_idx;
	logic [16:0] last_ext;
	logic [16:0] frac;
	logic [PW-1:0] pos;
	logic [W+18:0] num;
	logic [W:0]    w0;

	// Linear mode maps the pixel center: (2d+1)*scale in units of 2^-17.
	assign mult_op = (linear == MODE_LINEAR_BIT) ? {coord, 1'b1} : {1'b0, coord};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= 33'(mult_op) * 33'(scale);
			linear_s1 <= linear;
		end
	end

	assign t        = {2'b00, prod_s1} - 35'd65536;
	assign t_int    = t[33:17];
	assign t_frac   = t[16:0];
	assign near_idx = prod_s1[32:16];
	assign last_ext = 17'(last_idx);

	always_comb begin
		frac = '0;
		pos  = last_idx;
		if (linear_s1 == MODE_LINEAR_BIT) begin
			if (t[34]) begin
				pos = '0;
			end else if (t_int >= last_ext) begin
				pos = last_idx;
			end else begin
				pos  = PW'(t_int);
				frac = t_frac;
			end
		end else begin
			if (near_idx > last_ext) begin
				pos = last_idx;
			end else begin
				pos = PW'(near_idx);
			end
		end
	end

	// Round (1 - f) * 2^W half up; nearest mode puts all weight on one tap.
	assign num = ((W+19)'(18'h20000 - {1'b0, frac}) << W) + (W+19)'(17'h10000);
	assign w0  = (linear_s1 == MODE_LINEAR_BIT) ? num[W+17:17] : ONE;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos;
			w0_s2  <= w0;
		end
	end

endmodule

>>> src/irb_bank.sv
// -----------------------------------------------------------------------------
// irb_bank: one bank of the source frame memory
// Single port: a registered read per enabled cycle, plus a write when we is set.
// -----------------------------------------------------------------------------
module irb_bank #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [23:0]   wdata,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

>>> src/irb_lane.sv
// -----------------------------------------------------------------------------
// irb_lane: blend of one color channel
// Weighs the four neighbor samples and drops the fraction bits of the sum.
// -----------------------------------------------------------------------------
module irb_lane #(
	parameter int W = 11
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [3:0][7:0]      pix,
	input  logic [3:0][2*W:0]    wgt,
	output logic [7:0]           chan
);

	logic [3:0][2*W+8:0] prod_s5;
	logic [2*W+10:0]     sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s5[i] <= (2*W+9)'(pix[i]) * (2*W+9)'(wgt[i]);
			end
		end
	end

	assign sum  = (2*W+11)'(prod_s5[0]) + (2*W+11)'(prod_s5[1])
	            + (2*W+11)'(prod_s5[2]) + (2*W+11)'(prod_s5[3]);
	assign chan = sum[2*W+7:2*W];

endmodule

>>> src/image_resize_bilinear.sv
// Bilinear image resizer: takes one beat per clock, writes and queries alike, and
// answers each query in order, with the result held in an output register;
// while a finished pixel waits on the output, the whole pipeline and the input
// hold. The rate is set by the frame memory, split into four single-port banks
// by row and column parity, which delivers all four neighbors of a sample in a
// single read.
// The frame needs no clearing after reset; each pixel must be written before a
// query reads it.
// -----------------------------------------------------------------------------
// image_resize_bilinear: top level of the image resizer
// Coordinate mapping, banked frame memory, three channel lanes and the output
// register that merges them.
// -----------------------------------------------------------------------------
module image_resize_bilinear #(
	parameter int MAX_COLS    = 512,
	parameter int MAX_ROWS    = 512,
	parameter int WEIGHT_BITS = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	irb_stream_if.sink   src,
	irb_stream_if.source dst,
	irb_stream_if.sink   cfg
);

	localparam int W     = WEIGHT_BITS;
	localparam int CPW   = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
	localparam int RPW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
	localparam int HC    = (MAX_COLS + 1) / 2;
	localparam int HR    = (MAX_ROWS + 1) / 2;
	localparam int DEPTH = HR * HC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [W:0] ONE = (W+1)'(1) << W;

	// Configuration registers.
	logic [19:0] scale_x_q, scale_y_q;
	logic [9:0]  width_q, height_q;
	logic        mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= irb_pkg::SCALE_RESET;
			scale_y_q <= irb_pkg::SCALE_RESET;
			width_q   <= irb_pkg::SIZE_RESET;
			height_q  <= irb_pkg::SIZE_RESET;
			mode_q    <= irb_pkg::MODE_LINEAR;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				irb_pkg::CFG_SCALE_X:       scale_x_q <= cfg.data.value;
				irb_pkg::CFG_SCALE_Y:       scale_y_q <= cfg.data.value;
				irb_pkg::CFG_SOURCE_WIDTH:  width_q   <= cfg.data.value[9:0];
				irb_pkg::CFG_SOURCE_HEIGHT: height_q  <= cfg.data.value[9:0];
				irb_pkg::CFG_INTERP_MODE:   mode_q    <= cfg.data.value[0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Last valid index per axis, with zero sizes read as one and larger sizes clamped to the memory.
	logic [CPW-1:0] last_col;
	logic [RPW-1:0] last_row;

	always_comb begin
		if (width_q == 10'd0) begin
			last_col = '0;
		end else if (13'(width_q) > 13'(MAX_COLS)) begin
			last_col = CPW'(MAX_COLS - 1);
		end else begin
			last_col = CPW'(13'(width_q) - 13'd1);
		end
		if (height_q == 10'd0) begin
			last_row = '0;
		end else if (13'(height_q) > 13'(MAX_ROWS)) begin
			last_row = RPW'(MAX_ROWS - 1);
		end else begin
			last_row = RPW'(13'(height_q) - 13'd1);
		end
	end

	// The whole pipeline advances together whenever the output can move.
	logic en;
	logic out_valid_q;

	assign en        = !out_valid_q || dst.ready;
	assign src.ready = en;

	// Stages 1 and 2: coordinate mapping, write fields carried alongside.
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic        act_s1, act_s2, act_s3, act_s4, act_s5;
	logic [11:0] row_s1, col_s1, row_s2, col_s2;
	logic [23:0] wdata_s1, wdata_s2, wdata_s3;

	logic [RPW-1:0] ypos_s2;
	logic [CPW-1:0] xpos_s2;
	logic [W:0]     wy0_s2, wx0_s2;

	irb_axis #(.PW(RPW), .W(W)) u_axis_y (
		.clk      (clk),
		.en       (en),
		.coord    (src.data.pos_row),
		.scale    (scale_y_q),
		.linear   (mode_q),
		.last_idx (last_row),
		.pos_s2   (ypos_s2),
		.w0_s2    (wy0_s2)
	);

	irb_axis #(.PW(CPW), .W(W)) u_axis_x (
		.clk      (clk),
		.en       (en),
		.coord    (src.data.pos_col),
		.scale    (scale_x_q),
		.linear   (mode_q),
		.last_idx (last_col),
		.pos_s2   (xpos_s2),
		.w0_s2    (wx0_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= src.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= src.data.action;
			row_s1   <= src.data.pos_row;
			col_s1   <= src.data.pos_col;
			wdata_s1 <= {src.data.in_chan2, src.data.in_chan1, src.data.in_chan0};
			act_s2   <= act_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			wdata_s2 <= wdata_s1;
		end
	end

	// Stage 3: bank addresses and weight products. Bank k holds row parity k[1]
	// and column parity k[0]; the even bank of an axis serves index (p+1)/2.
	logic [1:0][RPW-1:0] rsel;
	logic [1:0][CPW-1:0] csel;
	logic [3:0][AW-1:0]  addr, addr_s3;
	logic [3:0]          we, we_s3;
	logic                wr_ok;
	logic [W:0]          wy1, wx1;
	logic [3:0][2*W:0]   wp_s3, wp_s4;
	logic                ypar_s3, xpar_s3, ypar_s4, xpar_s4;

	assign wr_ok = (vld_s2 && act_s2 == irb_pkg::ACT_WRITE)
	            && (13'(row_s2) < 13'(MAX_ROWS)) && (13'(col_s2) < 13'(MAX_COLS));

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			if (act_s2 == irb_pkg::ACT_WRITE) begin
				rsel[p] = RPW'(row_s2 >> 1);
				csel[p] = CPW'(col_s2 >> 1);
			end else begin
				rsel[p] = RPW'(((RPW+1)'(ypos_s2) + (RPW+1)'(1 - p)) >> 1);
				csel[p] = CPW'(((CPW+1)'(xpos_s2) + (CPW+1)'(1 - p)) >> 1);
			end
		end
		for (int k = 0; k < 4; k++) begin
			addr[k] = AW'((AW+2)'(rsel[k/2]) * (AW+2)'(HC) + (AW+2)'(csel[k%2]));
			we[k]   = wr_ok && (row_s2[0] == 1'(k/2)) && (col_s2[0] == 1'(k%2));
		end
	end

	assign wy1 = ONE - wy0_s2;
	assign wx1 = ONE - wx0_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s3  <= addr;
			wdata_s3 <= wdata_s2;
			act_s3   <= act_s2;
			ypar_s3  <= ypos_s2[0];
			xpar_s3  <= xpos_s2[0];
			wp_s3[0] <= (2*W+1)'(wx0_s2) * (2*W+1)'(wy0_s2);
			wp_s3[1] <= (2*W+1)'(wx0_s2) * (2*W+1)'(wy1);
			wp_s3[2] <= (2*W+1)'(wx1) * (2*W+1)'(wy0_s2);
			wp_s3[3] <= (2*W+1)'(wx1) * (2*W+1)'(wy1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s3 <= '0;
		end else if (en) begin
			we_s3 <= we;
		end
	end

	// Stage 4: frame memory read.
	logic [3:0][23:0] rd_s4;

	for (genvar k = 0; k < 4; k++) begin : g_bank
		irb_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
			.clk   (clk),
			.en    (en),
			.we    (we_s3[k]),
			.addr  (addr_s3[k]),
			.wdata (wdata_s3),
			.rdata (rd_s4[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wp_s4   <= wp_s3;
			ypar_s4 <= ypar_s3;
			xpar_s4 <= xpar_s3;
			act_s4  <= act_s3;
			act_s5  <= act_s4;
		end
	end

	// A neighbor past the edge has zero weight; its bank may hold anything.
	logic [3:0][23:0] nb;

	always_comb begin
		nb[0] = rd_s4[{ypar_s4, xpar_s4}];
		nb[1] = rd_s4[{~ypar_s4, xpar_s4}];
		nb[2] = rd_s4[{ypar_s4, ~xpar_s4}];
		nb[3] = rd_s4[{~ypar_s4, ~xpar_s4}];
		for (int i = 0; i < 4; i++) begin
			if (wp_s4[i] == '0) begin
				nb[i] = '0;
			end
		end
	end

	// Stage 5: one lane per color channel.
	logic [2:0][7:0] chan;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [3:0][7:0] pix;

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				pix[i] = nb[i][8*c +: 8];
			end
		end

		irb_lane #(.W(W)) u_lane (
			.clk  (clk),
			.en   (en),
			.pix  (pix),
			.wgt  (wp_s4),
			.chan (chan[c])
		);
	end

	// Stage 6: output register merging the lanes.
	irb_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s5 && (act_s5 == irb_pkg::ACT_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.out_chan0 <= chan[0];
			out_q.out_chan1 <= chan[1];
			out_q.out_chan2 <= chan[2];
		end
	end

	assign dst.valid = out_valid_q;
	assign dst.data  = out_q;

`ifndef SYNTH
	a_row_edge_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && act_s2 == irb_pkg::ACT_QUERY && ypos_s2 == last_row) |-> wy0_s2 == ONE)
		else $error("row at the edge carries weight on the clamped neighbor");

	a_col_edge_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && act_s2 == irb_pkg::ACT_QUERY && xpos_s2 == last_col) |-> wx0_s2 == ONE)
		else $error("column at the edge carries weight on the clamped neighbor");

	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s5 && act_s5 == irb_pkg::ACT_QUERY))
		else $error("result beat not caused by a query");
`endif

endmodule

>>> verif/image_resize_bilinear_checker.sv
// -----------------------------------------------------------------------------
// image_resize_bilinear_checker: pixel predictor and result comparator
// Watches the configuration, pixel and result channels of the resizer. It keeps
// its own copy of the register settings and of the frame, and works out every
// query's output pixel. Each result beat is compared with the oldest waiting
// pixel.
// -----------------------------------------------------------------------------
module image_resize_bilinear_checker (
	input  logic              clk,
	input  logic              arst_n,
	irb_stream_if.sink        src,
	irb_stream_if.sink        dst,
	irb_stream_if.sink        cfg,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS  = 512;
	localparam int ROWS  = 512;
	localparam int WBITS = 11;

	logic [23:0]        frame_px [ROWS*COLS];
	logic [19:0]        step_x, step_y;
	logic [9:0]         cols_reg, rows_reg;
	logic               mode_reg;
	irb_pkg::out_item_t pixel_queue [$];

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int clip_size(input logic [9:0] v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	// One axis of the linear map: integer position and leading weight.
	function automatic void axis_map(input longint d, input longint step, input int size,
			output longint pos, output longint w0);
		longint t, p, f;
		t = (2*d + 1) * step - 65536;
		if (t < 0) begin
			p = -1;
			f = t + 131072;
		end else begin
			p = t >>> 17;
			f = t & 131071;
		end
		if (p < 0) begin
			p = 0;
			f = 0;
		end
		if (p >= size - 1) begin
			p = size - 1;
			f = 0;
		end
		pos = p;
		w0 = ((131072 - f) * (1 << WBITS) + 65536) >>> 17;
	endfunction

	function automatic irb_pkg::out_item_t resize_pixel(input logic [11:0] row,
			input logic [11:0] col);
		irb_pkg::out_item_t r;
		int                 w, h;
		longint             sy, sx, sy1, sx1, wy0, wx0, wy1, wx1, sum;
		logic [23:0]        a, b, c, e, px;
		logic [7:0]         ch [3];
		w = clip_size(cols_reg, COLS);
		h = clip_size(rows_reg, ROWS);
		if (mode_reg == irb_pkg::MODE_NEAREST) begin
			sy = (longint'(row) * longint'(step_y)) >> 16;
			sx = (longint'(col) * longint'(step_x)) >> 16;
			if (sy > h - 1) sy = h - 1;
			if (sx > w - 1) sx = w - 1;
			px = frame_px[sy*COLS + sx];
			for (int k = 0; k < 3; k++) ch[k] = px[8*k +: 8];
		end else begin
			axis_map(longint'(row), longint'(step_y), h, sy, wy0);
			axis_map(longint'(col), longint'(step_x), w, sx, wx0);
			wy1 = (1 << WBITS) - wy0;
			wx1 = (1 << WBITS) - wx0;
			sy1 = (sy + 1 > h - 1) ? h - 1 : sy + 1;
			sx1 = (sx + 1 > w - 1) ? w - 1 : sx + 1;
			a = frame_px[sy*COLS + sx];
			b = frame_px[sy1*COLS + sx];
			c = frame_px[sy*COLS + sx1];
			e = frame_px[sy1*COLS + sx1];
			for (int k = 0; k < 3; k++) begin
				sum = longint'(a[8*k +: 8])*wx0*wy0 + longint'(b[8*k +: 8])*wx0*wy1
					+ longint'(c[8*k +: 8])*wx1*wy0 + longint'(e[8*k +: 8])*wx1*wy1;
				ch[k] = 8'(sum >> (2*WBITS));
			end
		end
		r.out_chan0 = ch[0];
		r.out_chan1 = ch[1];
		r.out_chan2 = ch[2];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		irb_pkg::out_item_t want;
		if (!arst_n) begin
			step_x     <= irb_pkg::SCALE_RESET;
			step_y     <= irb_pkg::SCALE_RESET;
			cols_reg   <= irb_pkg::SIZE_RESET;
			rows_reg   <= irb_pkg::SIZE_RESET;
			mode_reg   <= irb_pkg::MODE_LINEAR;
			fail_count = 0;
			pixel_queue.delete();
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					irb_pkg::CFG_SCALE_X: step_x <= cfg.data.value;
					irb_pkg::CFG_SCALE_Y: step_y <= cfg.data.value;
					irb_pkg::CFG_SOURCE_WIDTH: cols_reg <= cfg.data.value[9:0];
					irb_pkg::CFG_SOURCE_HEIGHT: rows_reg <= cfg.data.value[9:0];
					irb_pkg::CFG_INTERP_MODE: mode_reg <= cfg.data.value[0];
					default: ;
				endcase
			end
			if (src.valid && src.ready) begin
				if (src.data.action == irb_pkg::ACT_WRITE) begin
					if (src.data.pos_row < ROWS && src.data.pos_col < COLS)
						frame_px[src.data.pos_row*COLS + src.data.pos_col] =
							{src.data.in_chan2, src.data.in_chan1, src.data.in_chan0};
				end else begin
					pixel_queue = {pixel_queue,
						resize_pixel(src.data.pos_row, src.data.pos_col)};
				end
			end
			if (dst.valid && dst.ready) begin
				if (pixel_queue.size() == 0) begin
					$display("unexpected result beat at %0t", $realtime);
					fail_count++;
				end else begin
					want = pixel_queue.pop_front();
					if (dst.data.out_chan0 !== want.out_chan0)
						report("out_chan0", dst.data.out_chan0, want.out_chan0);
					if (dst.data.out_chan1 !== want.out_chan1)
						report("out_chan1", dst.data.out_chan1, want.out_chan1);
					if (dst.data.out_chan2 !== want.out_chan2)
						report("out_chan2", dst.data.out_chan2, want.out_chan2);
				end
			end
			pending = pixel_queue.size();
		end
	end

endmodule

>>> verif/image_resize_bilinear_test.sv
// -----------------------------------------------------------------------------
// image_resize_bilinear_test: testbench top of the image resizer
// Writes small source images, then queries destination pixels under several
// scale, size and mode settings, with random idling on both channels and one
// long output stall. The checker predicts and compares every result.
// -----------------------------------------------------------------------------
module image_resize_bilinear_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	bit   quiet = 1'b0;
	bit   hold_off = 1'b0;
	int   frame_rows = 1;
	int   frame_cols = 1;

	irb_stream_if #(irb_pkg::in_item_t)  src ();
	irb_stream_if #(irb_pkg::out_item_t) dst ();
	irb_stream_if #(irb_pkg::cfg_item_t) cfg ();

	image_resize_bilinear dut (.clk(clk), .arst_n(arst_n), .src(src), .dst(dst), .cfg(cfg));

	image_resize_bilinear_checker checker_i (.clk(clk), .arst_n(arst_n), .src(src),
		.dst(dst), .cfg(cfg), .fail_count(fail_count), .pending(pending));

	always #1 clk = ~clk;

	initial begin
		src.valid = 1'b0;
		src.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		dst.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stall bursts, or a long hold-off when asked.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				dst.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 6);
				dst.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				dst.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Valid stays up after a beat; the caller drops it when the sender goes idle.
	task automatic send_beat(input irb_pkg::in_item_t it);
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 6);
			src.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		src.valid <= 1'b1;
		src.data <= it;
		do @(posedge clk); while (!src.ready);
	endtask

	task automatic write_px(input int r, input int c);
		irb_pkg::in_item_t it;
		it.action = irb_pkg::ACT_WRITE;
		it.pos_row = 12'(r);
		it.pos_col = 12'(c);
		it.in_chan0 = 8'($urandom);
		it.in_chan1 = 8'($urandom);
		it.in_chan2 = 8'($urandom);
		send_beat(it);
	endtask

	task automatic query_px(input int r, input int c);
		irb_pkg::in_item_t it;
		it.action = irb_pkg::ACT_QUERY;
		it.pos_row = 12'(r);
		it.pos_col = 12'(c);
		it.in_chan0 = 8'($urandom);
		it.in_chan1 = 8'($urandom);
		it.in_chan2 = 8'($urandom);
		send_beat(it);
	endtask

	task automatic wait_idle;
		src.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [19:0] val);
		cfg.valid <= 1'b1;
		cfg.data <= '{index: idx, value: val};
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Writes a whole frame of the given size; the stored image covers every read.
	task automatic load_frame(input int rows, input int cols);
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < cols; c++) write_px(r, c);
		frame_rows = rows;
		frame_cols = cols;
	endtask

	task automatic setup(input logic [19:0] sx, input logic [19:0] sy, input logic [9:0] w,
			input logic [9:0] h, input logic m);
		wait_idle();
		set_reg(irb_pkg::CFG_SCALE_X, sx);
		set_reg(irb_pkg::CFG_SCALE_Y, sy);
		set_reg(irb_pkg::CFG_SOURCE_WIDTH, 20'(w));
		set_reg(irb_pkg::CFG_SOURCE_HEIGHT, 20'(h));
		set_reg(irb_pkg::CFG_INTERP_MODE, 20'(m));
		cfg.valid <= 1'b0;
	endtask

	task automatic random_queries(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				write_px($urandom_range(0, frame_rows - 1), $urandom_range(0, frame_cols - 1));
			else if ($urandom_range(0, 9) == 0)
				query_px($urandom_range(0, 4095), $urandom_range(0, 4095));
			else
				query_px($urandom_range(0, 40), $urandom_range(0, 40));
		end
	endtask

	initial begin
		irb_pkg::in_item_t it;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full memory corners, writes outside memory, reset scales, extreme scales and sizes.
		write_px(511, 511);
		write_px(0, 0);
		write_px(0, 511);
		write_px(511, 0);
		it = '1;
		it.action = irb_pkg::ACT_WRITE;
		send_beat(it);
		it.pos_row = 12'd512;
		it.pos_col = 12'd3;
		send_beat(it);
		load_frame(8, 8);
		setup(irb_pkg::SCALE_RESET, irb_pkg::SCALE_RESET, 10'd8, 10'd8, irb_pkg::MODE_LINEAR);
		query_px(0, 0);
		query_px(4095, 4095);
		query_px(3, 5);
		setup(20'hFFFFF, 20'd1, 10'd0, 10'd1023, irb_pkg::MODE_NEAREST);
		query_px(4095, 4095);
		query_px(0, 7);
		setup(20'd0, 20'd0, 10'd8, 10'd8, irb_pkg::MODE_LINEAR);
		query_px(9, 9);
		setup(20'd32768, 20'd98304, 10'd8, 10'd8, irb_pkg::MODE_LINEAR);
		query_px(7, 2);
		query_px(1, 6);
		wait_idle();

		// Long output stall while the input keeps coming.
		hold_off = 1'b1;
		random_queries(30);
		wait_idle();

		load_frame(12, 12);
		setup(20'd21845, 20'd43690, 10'd12, 10'd12, irb_pkg::MODE_LINEAR);
		random_queries(50);
		setup(20'd150000, 20'd70000, 10'd12, 10'd9, irb_pkg::MODE_NEAREST);
		random_queries(40);
		setup(20'd1, 20'hFFFFF, 10'd1, 10'd12, irb_pkg::MODE_LINEAR);
		random_queries(30);
		setup(20'd12345, 20'd54321, 10'd11, 10'd10, irb_pkg::MODE_LINEAR);
		quiet = 1'b1;
		random_queries(40);

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> files.f
src/irb_pkg.sv
src/irb_stream_if.sv
src/irb_axis.sv
src/irb_bank.sv
src/irb_lane.sv
src/image_resize_bilinear.sv
verif/image_resize_bilinear_checker.sv
verif/image_resize_bilinear_test.sv
